[rtl/core/snfc_pkg.sv]
// Shared types, constants and comparator helpers of the sorting network fitness checker.
package snfc_pkg;

  localparam int VEC_W      = 16;
  localparam int GENE_SLOTS = 64;
  localparam int SLOT_W     = 6;
  localparam int POS_W      = 4;
  localparam int TALLY_W    = 24;
  localparam int ZC_W       = 5;
  localparam int CFG_W      = 7;
  localparam int ACT_W      = 2;

  // Operation codes carried by an input item.
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TEST  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // One gene: two comparators, packed as held in each cell.
  typedef struct packed {
    logic [POS_W-1:0] two_hi;
    logic [POS_W-1:0] two_lo;
    logic [POS_W-1:0] one_hi;
    logic [POS_W-1:0] one_lo;
  } gene_t;

  // Contents of one chain stage as it moves from cell to cell.
  typedef struct packed {
    logic              valid;
    action_t           action;
    logic [SLOT_W-1:0] slot;
    gene_t             gene;
    logic [VEC_W-1:0]  bits;
    logic [ZC_W-1:0]   zero_count;
  } stage_t;

  // A single compare-exchange on a zero-one vector.
  function automatic logic [VEC_W-1:0] apply_cmp(input logic [VEC_W-1:0] v,
                                                 input logic [POS_W-1:0] p,
                                                 input logic [POS_W-1:0] q);
    logic [POS_W-1:0] a;
    logic [POS_W-1:0] b;
    logic [VEC_W-1:0] r;
    a = (p < q) ? p : q;
    b = (p < q) ? q : p;
    r = v;
    if (a != b && 32'(b) < VEC_W) begin
      if (v[a] && !v[b]) begin
        r[a] = 1'b0;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  // One gene: the first comparator, then the second unless both are the same.
  function automatic logic [VEC_W-1:0] apply_gene(input logic [VEC_W-1:0] v,
                                                  input gene_t g);
    logic [VEC_W-1:0] r;
    r = apply_cmp(v, g.one_lo, g.one_hi);
    if (g.one_lo != g.two_lo || g.one_hi != g.two_hi) begin
      r = apply_cmp(r, g.two_lo, g.two_hi);
    end
    return r;
  endfunction

endpackage

[rtl/core/snfc_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface snfc_in_if;
  logic                                valid;
  logic                                ready;
  logic [snfc_pkg::ACT_W-1:0]          action;
  logic [snfc_pkg::SLOT_W-1:0]         gene_slot;
  logic [snfc_pkg::POS_W-1:0]          pair_one_lo;
  logic [snfc_pkg::POS_W-1:0]          pair_one_hi;
  logic [snfc_pkg::POS_W-1:0]          pair_two_lo;
  logic [snfc_pkg::POS_W-1:0]          pair_two_hi;
  logic [15:0]                         test_bits;
  logic [snfc_pkg::ZC_W-1:0]           zero_count;

  modport source (output valid, action, gene_slot, pair_one_lo, pair_one_hi,
                  pair_two_lo, pair_two_hi, test_bits, zero_count, input ready);
  modport sink (input valid, action, gene_slot, pair_one_lo, pair_one_hi,
                pair_two_lo, pair_two_hi, test_bits, zero_count, output ready);
endinterface

interface snfc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          sorted_ok;
  logic [snfc_pkg::TALLY_W-1:0]  passed_tests;
  logic [snfc_pkg::TALLY_W-1:0]  total_tests;

  modport source (output valid, sorted_ok, passed_tests, total_tests, input ready);
  modport sink (input valid, sorted_ok, passed_tests, total_tests, output ready);
endinterface

[rtl/core/snfc_cell.sv]
// One cell of the comparator chain: holds one gene and applies it to passing vectors.
module snfc_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [snfc_pkg::SLOT_W-1:0]   cell_index,
  input  logic                          active,
  input  snfc_pkg::stage_t              stage_in,
  output snfc_pkg::stage_t              stage_out
);

  snfc_pkg::gene_t  gene;
  snfc_pkg::stage_t stage_next;

  // A test item in an active cell is run through this cell's comparators.
  always_comb begin
    stage_next = stage_in;
    if (stage_in.valid && stage_in.action == snfc_pkg::ACT_TEST && active) begin
      stage_next.bits = snfc_pkg::apply_gene(stage_in.bits, gene);
    end
  end

  // The gene is captured when a load item for this slot passes, so it takes
  // effect exactly for the test items that follow the load.
  always_ff @(posedge clk) begin
    if (advance && stage_in.valid && stage_in.action == snfc_pkg::ACT_LOAD &&
        stage_in.slot == cell_index) begin
      gene <= stage_in.gene;
    end
  end

  // Stage register toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (advance) begin
      stage_out <= stage_next;
    end
  end

endmodule

[rtl/core/snfc_tally.sv]
// End of the chain: checks the sorted pattern, keeps the tallies and holds the result item.
module snfc_tally (
  input  logic              clk,
  input  logic              rst,
  input  snfc_pkg::stage_t  stage_in,
  output logic              advance,
  snfc_out_if.source        results
);

  logic                         res_valid;
  logic                         ok;
  logic [snfc_pkg::TALLY_W-1:0] pass_tally;
  logic [snfc_pkg::TALLY_W-1:0] test_tally;
  logic [snfc_pkg::VEC_W-1:0]   expect_bits;
  logic [snfc_pkg::ZC_W-1:0]    zc_clamped;
  logic                         ok_next;

  // The chain moves whenever the result register is free or being emptied.
  assign advance = !res_valid || results.ready;

  // Expected pattern: zeros below the clamped zero count, ones above.
  always_comb begin
    zc_clamped = (32'(stage_in.zero_count) > snfc_pkg::VEC_W) ?
                 snfc_pkg::ZC_W'(snfc_pkg::VEC_W) : stage_in.zero_count;
    for (int i = 0; i < snfc_pkg::VEC_W; i++) begin
      expect_bits[i] = (i >= 32'(zc_clamped));
    end
    ok_next = (stage_in.bits == expect_bits);
  end

  // Tallies and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      pass_tally <= '0;
      test_tally <= '0;
    end else if (advance) begin
      res_valid <= stage_in.valid && stage_in.action == snfc_pkg::ACT_TEST;
      if (stage_in.valid) begin
        case (stage_in.action)
          snfc_pkg::ACT_TEST: begin
            ok <= ok_next;
            if (test_tally != '1) begin
              test_tally <= test_tally + 1'b1;
            end
            if (ok_next && pass_tally != '1) begin
              pass_tally <= pass_tally + 1'b1;
            end
          end
          snfc_pkg::ACT_CLEAR: begin
            pass_tally <= '0;
            test_tally <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign results.valid        = res_valid;
  assign results.sorted_ok    = ok;
  assign results.passed_tests = pass_tally;
  assign results.total_tests  = test_tally;

endmodule

[rtl/core/sorting_network_fitness_checker.sv]
// Top level of the sorting network fitness checker: input stage, cell chain and tally stage.
//
// Usage: items enter on the items channel (valid/ready). A load item writes one
// gene into the cell of its slot, a test item runs a zero-one vector through the
// comparators of slots 0 .. genes_in_use-1, a clear item zeroes both tallies, and
// action code 3 is dropped at the input. Only test items give a result item on
// the results channel: sorted_ok and the saturating pass and test tallies.
// Every item travels through a chain of 64 cells, one cell per gene slot, so
// loads, tests and clears take effect strictly in order. A test item passes the
// stage register of each cell and then the result register; throughput is one
// item per cycle while no result is stalled. The user must write genes_in_use
// through cfg_write_en/cfg_write_data only while idle; the block does not check.
// Reset clears the chain's valid bits, the result register and both tallies and
// sets genes_in_use to 64; gene contents are undefined until loaded.
// When the receiver stalls a pending result, the whole chain holds and items
// ready drops until the result is taken.
module sorting_network_fitness_checker (
  input  logic                        clk,
  input  logic                        rst,
  snfc_in_if.sink                     items,
  snfc_out_if.source                  results,
  input  logic                        cfg_write_en,
  input  logic [snfc_pkg::CFG_W-1:0]  cfg_write_data
);

  logic                          advance;
  logic [snfc_pkg::CFG_W-1:0]    genes_in_use;
  snfc_pkg::stage_t              chain [0:snfc_pkg::GENE_SLOTS];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      genes_in_use <= snfc_pkg::CFG_W'(snfc_pkg::GENE_SLOTS);
    end else if (cfg_write_en) begin
      genes_in_use <= cfg_write_data;
    end
  end

  assign items.ready = advance;

  // Entry of the chain; the unused action code enters as a bubble.
  always_comb begin
    chain[0].valid       = items.valid && items.ready &&
                           (items.action == snfc_pkg::ACT_LOAD ||
                            items.action == snfc_pkg::ACT_TEST ||
                            items.action == snfc_pkg::ACT_CLEAR);
    chain[0].action      = snfc_pkg::action_t'(items.action);
    chain[0].slot        = items.gene_slot;
    chain[0].gene.one_lo = items.pair_one_lo;
    chain[0].gene.one_hi = items.pair_one_hi;
    chain[0].gene.two_lo = items.pair_two_lo;
    chain[0].gene.two_hi = items.pair_two_hi;
    chain[0].bits        = items.test_bits[snfc_pkg::VEC_W-1:0];
    chain[0].zero_count  = items.zero_count;
  end

  // Row of cells, one per gene slot.
  for (genvar i = 0; i < snfc_pkg::GENE_SLOTS; i++) begin : g_cell
    localparam logic [snfc_pkg::CFG_W-1:0]  CellNum  = snfc_pkg::CFG_W'(i);
    localparam logic [snfc_pkg::SLOT_W-1:0] CellSlot = snfc_pkg::SLOT_W'(i);

    snfc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .cell_index (CellSlot),
      .active     (CellNum < genes_in_use),
      .stage_in   (chain[i]),
      .stage_out  (chain[i+1])
    );
  end

  // Pattern check, tallies and result register.
  snfc_tally u_tally (
    .clk      (clk),
    .rst      (rst),
    .stage_in (chain[snfc_pkg::GENE_SLOTS]),
    .advance  (advance),
    .results  (results)
  );

endmodule

[rtl/core/snfc_checker.sv]
// Port-level checks of the sorting network fitness checker, bound to the top level.
module snfc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          sorted_ok,
  input logic [snfc_pkg::TALLY_W-1:0]  passed_tests,
  input logic [snfc_pkg::TALLY_W-1:0]  total_tests
);

  // A stalled result stays and keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(passed_tests) &&
                                $stable(total_tests) && $stable(sorted_ok))
    else $error("stalled result changed");

  // No result is shown in the first cycle out of reset.
  assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // Input is refused only while a result waits on a stalled receiver.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // The pass tally never exceeds the test tally.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> passed_tests <= total_tests)
    else $error("pass tally above test tally");

  // A passing vector leaves a nonzero pass tally.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && sorted_ok |-> passed_tests != '0 && total_tests != '0)
    else $error("passing result with zero tally");

endmodule

bind sorting_network_fitness_checker snfc_checker u_snfc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (items.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .sorted_ok    (results.sorted_ok),
  .passed_tests (results.passed_tests),
  .total_tests  (results.total_tests)
);
